[sv/tdm_pkg.sv]
// Shared types, constants and table helpers for the tanh distortion mixer.
package tdm_pkg;

    localparam int TDM_TABLE_ENTRIES = 256;

    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 19;
    localparam int DRIVE_W    = 15;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int AX_W       = 30;
    localparam int FRAC_W     = 27;
    localparam int TANH_W     = 16;
    localparam int STAGES     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WET_WEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRY_WEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LEVEL = 3'd4;

    localparam logic [DRIVE_W-1:0] DRIVE_GAIN_RST  = 15'd1024;
    localparam logic [GAIN_W-1:0]  OUTPUT_GAIN_RST = 16'd16384;
    localparam logic [GAIN_W-1:0]  WET_WEIGHT_RST  = 16'd16384;
    localparam logic [GAIN_W-1:0]  DRY_WEIGHT_RST  = 16'd16384;
    localparam logic [GAIN_W-1:0]  CLAMP_LEVEL_RST = 16'd36766;

    localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
    localparam logic [63:0] Q30_HALF = 64'd1 << 29;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive_gain;
        logic [GAIN_W-1:0]  output_gain;
        logic [GAIN_W-1:0]  wet_weight;
        logic [GAIN_W-1:0]  dry_weight;
        logic [GAIN_W-1:0]  clamp_level;
    } cfg_t;

    typedef struct packed {
        logic [STAGES-1:0] valid;
        logic [STAGES-1:0] load;
    } pipe_ctl_t;

    // Repeated Q30 product e^(-u*n), clamped to one, used only at elaboration.
    function automatic logic [63:0] tdm_pow(logic [63:0] e, int n);
        logic [63:0] p;
        p = Q30_ONE;
        for (int j = 1; j <= n; j++)
        begin
            p = (p * e + Q30_HALF) >> 30;
            if (p > Q30_ONE)
            begin
                p = Q30_ONE;
            end
        end
        return p;
    endfunction

endpackage

[sv/tdm_ctrl.sv]
// Stage valid bits and per-stage advance logic for the mixer pipeline.
module tdm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    input  logic              result_stall,
    output logic              sample_stall,
    output tdm_pkg::pipe_ctl_t ctl
);
    import tdm_pkg::*;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] ready;
    logic [STAGES-1:0] feed;

    always_comb
    begin
        ready[STAGES-1] = !valid_reg[STAGES-1] || !result_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        feed = {valid_reg[STAGES-2:0], sample_valid};
        for (int k = 0; k < STAGES; k++)
        begin
            valid_next[k] = ready[k] ? feed[k] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.valid    = valid_reg;
    assign ctl.load     = ready & feed;
    assign sample_stall = !ready[0];

endmodule

[sv/tdm_front.sv]
// Front stages: drive scaling, dry clamp and tanh table index with fraction.
module tdm_front #(
    parameter int TANH_TABLE_ENTRIES = tdm_pkg::TDM_TABLE_ENTRIES
) (
    input  logic                                      clk,
    input  tdm_pkg::pipe_ctl_t                        ctl,
    input  tdm_pkg::cfg_t                             cfg,
    input  logic signed [tdm_pkg::SAMPLE_W-1:0]       sample_in,
    output logic [$clog2(TANH_TABLE_ENTRIES+1)-1:0]   idx,
    output logic [tdm_pkg::FRAC_W-1:0]                frac,
    output logic                                      sat,
    output logic                                      neg,
    output logic signed [tdm_pkg::SAMPLE_W-1:0]       dry
);
    import tdm_pkg::*;

    localparam int TW = $clog2(TANH_TABLE_ENTRIES + 1);
    localparam int QW = AX_W + TW;
    localparam int IW = QW - FRAC_W;

    logic [SAMPLE_W-1:0]        mag;
    logic [SAMPLE_W+DRIVE_W-1:0] ax_full;
    logic signed [SAMPLE_W+1:0] s_ext;
    logic signed [SAMPLE_W+1:0] lim_ext;
    logic signed [SAMPLE_W+1:0] dry_full;
    logic [AX_W-1:0]            ax_reg;
    logic                       neg0_reg;
    logic signed [SAMPLE_W-1:0] dry0_reg;
    logic [QW-1:0]              q;
    logic [IW-1:0]              idx_full;
    logic                       sat_next;
    logic [TW-1:0]              idx_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic                       sat_reg;
    logic                       neg_reg;
    logic signed [SAMPLE_W-1:0] dry_reg;

    always_comb
    begin
        mag     = sample_in[SAMPLE_W-1] ? (~sample_in + 1'b1) : sample_in;
        ax_full = mag * cfg.drive_gain;
        s_ext   = {{2{sample_in[SAMPLE_W-1]}}, sample_in};
        lim_ext = {2'b00, cfg.clamp_level};
        if (s_ext > lim_ext)
        begin
            dry_full = lim_ext;
        end
        else if (s_ext < -lim_ext)
        begin
            dry_full = -lim_ext;
        end
        else
        begin
            dry_full = s_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            ax_reg   <= ax_full[AX_W-1:0];
            neg0_reg <= sample_in[SAMPLE_W-1];
            dry0_reg <= dry_full[SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        q        = QW'(ax_reg) * QW'(TANH_TABLE_ENTRIES);
        idx_full = q[QW-1:FRAC_W];
        sat_next = idx_full >= IW'(TANH_TABLE_ENTRIES);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            idx_reg  <= sat_next ? '0 : idx_full[TW-1:0];
            frac_reg <= q[FRAC_W-1:0];
            sat_reg  <= sat_next;
            neg_reg  <= neg0_reg;
            dry_reg  <= dry0_reg;
        end
    end

    assign idx  = idx_reg;
    assign frac = frac_reg;
    assign sat  = sat_reg;
    assign neg  = neg_reg;
    assign dry  = dry_reg;

endmodule

[sv/tdm_rom.sv]
// Tanh table built at elaboration, with a registered read of two neighbors.
module tdm_rom #(
    parameter int TANH_TABLE_ENTRIES = tdm_pkg::TDM_TABLE_ENTRIES
) (
    input  logic                                     clk,
    input  tdm_pkg::pipe_ctl_t                       ctl,
    input  logic [$clog2(TANH_TABLE_ENTRIES+1)-1:0]  idx,
    input  logic [tdm_pkg::FRAC_W-1:0]               frac_in,
    input  logic                                     sat_in,
    input  logic                                     neg_in,
    input  logic signed [tdm_pkg::SAMPLE_W-1:0]      dry_in,
    output logic [tdm_pkg::TANH_W-1:0]               lo,
    output logic [tdm_pkg::TANH_W-1:0]               hi,
    output logic [tdm_pkg::FRAC_W-1:0]               frac,
    output logic                                     sat,
    output logic                                     neg,
    output logic signed [tdm_pkg::SAMPLE_W-1:0]      dry
);
    import tdm_pkg::*;

    localparam int TW = $clog2(TANH_TABLE_ENTRIES + 1);

    localparam logic [63:0] U   = (64'd8 << 30) / TANH_TABLE_ENTRIES;
    localparam logic [63:0] T1  = ((Q30_ONE * U) >> 30) / 1;
    localparam logic [63:0] T2  = ((T1 * U) >> 30) / 2;
    localparam logic [63:0] T3  = ((T2 * U) >> 30) / 3;
    localparam logic [63:0] T4  = ((T3 * U) >> 30) / 4;
    localparam logic [63:0] T5  = ((T4 * U) >> 30) / 5;
    localparam logic [63:0] T6  = ((T5 * U) >> 30) / 6;
    localparam logic [63:0] T7  = ((T6 * U) >> 30) / 7;
    localparam logic [63:0] T8  = ((T7 * U) >> 30) / 8;
    localparam logic [63:0] T9  = ((T8 * U) >> 30) / 9;
    localparam logic [63:0] T10 = ((T9 * U) >> 30) / 10;
    localparam logic [63:0] T11 = ((T10 * U) >> 30) / 11;
    localparam logic [63:0] T12 = ((T11 * U) >> 30) / 12;
    localparam logic [63:0] E   = Q30_ONE - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8
                                  - T9 + T10 - T11 + T12;

    logic [TANH_W-1:0] tbl [TANH_TABLE_ENTRIES+1];
    logic [TANH_W-1:0] lo_reg;
    logic [TANH_W-1:0] hi_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic              sat_reg;
    logic              neg_reg;
    logic signed [SAMPLE_W-1:0] dry_reg;

    for (genvar g = 0; g <= TANH_TABLE_ENTRIES; g++)
    begin : g_point
        localparam logic [63:0] P   = tdm_pow(E, g);
        localparam logic [63:0] NUM = (Q30_ONE - P) << 15;
        localparam logic [63:0] DEN = Q30_ONE + P;
        localparam logic [63:0] VAL = (NUM + DEN / 2) / DEN;
        assign tbl[g] = VAL[TANH_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[2])
        begin
            lo_reg   <= tbl[idx];
            hi_reg   <= tbl[idx + TW'(1)];
            frac_reg <= frac_in;
            sat_reg  <= sat_in;
            neg_reg  <= neg_in;
            dry_reg  <= dry_in;
        end
    end

    assign lo   = lo_reg;
    assign hi   = hi_reg;
    assign frac = frac_reg;
    assign sat  = sat_reg;
    assign neg  = neg_reg;
    assign dry  = dry_reg;

endmodule

[sv/tdm_mix.sv]
// Back stages: interpolation, dry and wet weighting, output gain and rounding.
module tdm_mix (
    input  logic                                 clk,
    input  tdm_pkg::pipe_ctl_t                   ctl,
    input  tdm_pkg::cfg_t                        cfg,
    input  logic [tdm_pkg::TANH_W-1:0]           lo,
    input  logic [tdm_pkg::TANH_W-1:0]           hi,
    input  logic [tdm_pkg::FRAC_W-1:0]           frac,
    input  logic                                 sat,
    input  logic                                 neg,
    input  logic signed [tdm_pkg::SAMPLE_W-1:0]  dry,
    output logic signed [tdm_pkg::OUT_W-1:0]     sample_out
);
    import tdm_pkg::*;

    localparam int PW = TANH_W + FRAC_W;
    localparam logic [PW-1:0] INTERP_HALF = PW'(1) << (FRAC_W - 1);
    localparam logic [TANH_W-1:0] WET_ONE = 16'd32768;
    localparam logic [48:0] ROUND_HALF = 49'd1 << 28;
    localparam logic [19:0] POS_LIMIT = 20'd262143;
    localparam logic [19:0] NEG_LIMIT = 20'd262144;

    logic [TANH_W-1:0]   diff;
    logic [PW-1:0]       step;
    logic [TANH_W-1:0]   y_next;
    logic [TANH_W-1:0]   y_reg;
    logic                neg3_reg;
    logic signed [SAMPLE_W-1:0] dry3_reg;

    logic signed [TANH_W:0] wet;
    logic signed [33:0]  pw_full;
    logic signed [32:0]  pd_full;
    logic signed [31:0]  pw_reg;
    logic signed [31:0]  pd_reg;

    logic signed [32:0]  mix;
    logic [32:0]         mix_mag;
    logic [31:0]         amix_reg;
    logic                sgn5_reg;

    logic [47:0]         v_full;
    logic [47:0]         av_reg;
    logic                sgn6_reg;

    logic [48:0]         rsum;
    logic [19:0]         r;
    logic [19:0]         m;
    logic signed [OUT_W-1:0] out_reg;

    always_comb
    begin
        diff   = (hi >= lo) ? (hi - lo) : '0;
        step   = diff * frac + INTERP_HALF;
        y_next = sat ? WET_ONE : (lo + step[PW-1:FRAC_W]);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[3])
        begin
            y_reg    <= y_next;
            neg3_reg <= neg;
            dry3_reg <= dry;
        end
    end

    always_comb
    begin
        wet     = neg3_reg ? -$signed({1'b0, y_reg}) : $signed({1'b0, y_reg});
        pw_full = $signed({1'b0, cfg.wet_weight}) * wet;
        pd_full = $signed({1'b0, cfg.dry_weight}) * dry3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[4])
        begin
            pw_reg <= pw_full[31:0];
            pd_reg <= pd_full[31:0];
        end
    end

    always_comb
    begin
        mix     = $signed({pw_reg[31], pw_reg}) + $signed({pd_reg[31], pd_reg});
        mix_mag = mix[32] ? 33'(-mix) : 33'(mix);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[5])
        begin
            amix_reg <= mix_mag[31:0];
            sgn5_reg <= mix[32];
        end
    end

    assign v_full = amix_reg * cfg.output_gain;

    always_ff @(posedge clk)
    begin
        if (ctl.load[6])
        begin
            av_reg   <= v_full;
            sgn6_reg <= sgn5_reg;
        end
    end

    always_comb
    begin
        rsum = {1'b0, av_reg} + ROUND_HALF;
        r    = rsum[48:29];
        if (sgn6_reg)
        begin
            m = (r > NEG_LIMIT) ? NEG_LIMIT : r;
        end
        else
        begin
            m = (r > POS_LIMIT) ? POS_LIMIT : r;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[7])
        begin
            out_reg <= sgn6_reg ? OUT_W'(-m) : OUT_W'(m);
        end
    end

    assign sample_out = out_reg;

endmodule

[sv/tanh_distortion_mix.sv]
// Top level of the tanh soft-clip distortion mixer with configuration registers.
//
//   Port group  Direction  Transaction
//   sample_*    in         one Q1.15 sample_in, taken when sample_valid and !sample_stall
//   result_*    out        one Q4.15 sample_out, taken when result_valid and !result_stall
//   cfg_*       in         register write on cfg_wr_en, index cfg_index, value cfg_data
//
// Eight register stages; a sample taken at the input passes through them in order
// and is presented at the output from the last one; one sample per cycle is
// sustained when the output is not stalled. Each stage advances on its own when
// the stage after it is empty or moving, so bubbles close up behind a stalled
// output. The tanh table read in the third stage and the multipliers set the
// stage depth. Reset clears the stage valid bits and loads the configuration
// registers with their defaults; no clearing pass is needed.
module tanh_distortion_mix #(
    parameter int TANH_TABLE_ENTRIES = tdm_pkg::TDM_TABLE_ENTRIES
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  logic signed [tdm_pkg::SAMPLE_W-1:0]   sample_in,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic signed [tdm_pkg::OUT_W-1:0]      sample_out,
    input  logic                                  cfg_wr_en,
    input  logic [tdm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tdm_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import tdm_pkg::*;

    localparam int TW = $clog2(TANH_TABLE_ENTRIES + 1);

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    pipe_ctl_t ctl;

    logic [TW-1:0]              f_idx;
    logic [FRAC_W-1:0]          f_frac;
    logic                       f_sat;
    logic                       f_neg;
    logic signed [SAMPLE_W-1:0] f_dry;
    logic [TANH_W-1:0]          r_lo;
    logic [TANH_W-1:0]          r_hi;
    logic [FRAC_W-1:0]          r_frac;
    logic                       r_sat;
    logic                       r_neg;
    logic signed [SAMPLE_W-1:0] r_dry;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DRIVE_GAIN:  cfg_next.drive_gain  = cfg_data[DRIVE_W-1:0];
                REG_OUTPUT_GAIN: cfg_next.output_gain = cfg_data;
                REG_WET_WEIGHT:  cfg_next.wet_weight  = cfg_data;
                REG_DRY_WEIGHT:  cfg_next.dry_weight  = cfg_data;
                REG_CLAMP_LEVEL: cfg_next.clamp_level = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_gain  <= DRIVE_GAIN_RST;
            cfg_reg.output_gain <= OUTPUT_GAIN_RST;
            cfg_reg.wet_weight  <= WET_WEIGHT_RST;
            cfg_reg.dry_weight  <= DRY_WEIGHT_RST;
            cfg_reg.clamp_level <= CLAMP_LEVEL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tdm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .result_stall (result_stall),
        .sample_stall (sample_stall),
        .ctl          (ctl)
    );

    tdm_front #(
        .TANH_TABLE_ENTRIES (TANH_TABLE_ENTRIES)
    ) u_front (
        .clk       (clk),
        .ctl       (ctl),
        .cfg       (cfg_reg),
        .sample_in (sample_in),
        .idx       (f_idx),
        .frac      (f_frac),
        .sat       (f_sat),
        .neg       (f_neg),
        .dry       (f_dry)
    );

    tdm_rom #(
        .TANH_TABLE_ENTRIES (TANH_TABLE_ENTRIES)
    ) u_rom (
        .clk     (clk),
        .ctl     (ctl),
        .idx     (f_idx),
        .frac_in (f_frac),
        .sat_in  (f_sat),
        .neg_in  (f_neg),
        .dry_in  (f_dry),
        .lo      (r_lo),
        .hi      (r_hi),
        .frac    (r_frac),
        .sat     (r_sat),
        .neg     (r_neg),
        .dry     (r_dry)
    );

    tdm_mix u_mix (
        .clk        (clk),
        .ctl        (ctl),
        .cfg        (cfg_reg),
        .lo         (r_lo),
        .hi         (r_hi),
        .frac       (r_frac),
        .sat        (r_sat),
        .neg        (r_neg),
        .dry        (r_dry),
        .sample_out (sample_out)
    );

    assign result_valid = ctl.valid[STAGES-1];

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> ((&ctl.valid) && result_stall))
        else $error("Input stalled while the pipeline has a free stage.");

    a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n |=> ($countones(ctl.valid) == $past($countones(ctl.valid))
            + int'($past(sample_valid && !sample_stall))
            - int'($past(result_valid && !result_stall))))
        else $error("Pipeline lost or duplicated a transaction.");
`endif

endmodule

[dv/tdm_mix_checker.sv]
// Checker that predicts every mixer output from the observed transactions and compares it.
`timescale 1ns / 100ps

module tdm_mix_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_valid,
    input  logic                                  sample_stall,
    input  logic signed [tdm_pkg::SAMPLE_W-1:0]   sample_in,
    input  logic                                  result_valid,
    input  logic                                  result_stall,
    input  logic signed [tdm_pkg::OUT_W-1:0]      sample_out,
    input  logic                                  cfg_wr_en,
    input  logic [tdm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tdm_pkg::CFG_DATA_W-1:0]        cfg_data,
    output int                                    fail_count,
    output int                                    pending
);
    import tdm_pkg::*;

    localparam int N = TDM_TABLE_ENTRIES;

    longint                  tanh_points [0:N];
    cfg_t                    shadow_cfg;
    logic signed [OUT_W-1:0] predicted_samples [$];
    logic signed [OUT_W-1:0] expected;

    initial
    begin
        longint step_u;
        longint term;
        longint series;
        longint decay;
        longint p_q30;
        longint num;
        longint den;
        step_u = (longint'(8) << 30) / N;
        term   = longint'(1) << 30;
        series = longint'(1) << 30;
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * step_u) >>> 30) / k;
            series = (k % 2 == 1) ? series - term : series + term;
        end
        decay = (series < 0) ? 0 : series;
        p_q30 = longint'(1) << 30;
        for (int i = 0; i <= N; i++)
        begin
            if (i > 0)
            begin
                p_q30 = (p_q30 * decay + (longint'(1) << 29)) >>> 30;
            end
            if (p_q30 > (longint'(1) << 30))
            begin
                p_q30 = longint'(1) << 30;
            end
            num = ((longint'(1) << 30) - p_q30) << 15;
            den = (longint'(1) << 30) + p_q30;
            tanh_points[i] = (num + den / 2) / den;
        end
    end

    function automatic logic signed [OUT_W-1:0] distort_and_mix(
        input logic signed [SAMPLE_W-1:0] x,
        input cfg_t                       c
    );
        longint mag;
        longint q;
        longint idx;
        longint frac;
        longint lo;
        longint hi;
        longint d;
        longint y;
        longint wet;
        longint dry;
        longint lim;
        longint mix;
        longint v;
        longint av;
        longint r;
        mag  = (x < 0) ? -longint'(x) : longint'(x);
        q    = mag * longint'(c.drive_gain) * N;
        idx  = q >>> 27;
        frac = q & ((longint'(1) << 27) - 1);
        if (idx < N)
        begin
            lo = tanh_points[idx];
            hi = tanh_points[idx + 1];
            d  = (hi >= lo) ? hi - lo : 0;
            y  = lo + ((d * frac + (longint'(1) << 26)) >>> 27);
        end
        else
        begin
            y = 32768;
        end
        wet = (x < 0) ? -y : y;
        lim = longint'(c.clamp_level);
        dry = longint'(x);
        if (dry > lim)
        begin
            dry = lim;
        end
        else if (dry < -lim)
        begin
            dry = -lim;
        end
        mix = longint'(c.dry_weight) * dry + longint'(c.wet_weight) * wet;
        v   = mix * longint'(c.output_gain);
        av  = (v < 0) ? -v : v;
        av  = (av + (longint'(1) << 28)) >>> 29;
        if (av > 262144)
        begin
            av = 262144;
        end
        r = (v < 0) ? -av : av;
        if (r > 262143)
        begin
            r = 262143;
        end
        if (r < -262144)
        begin
            r = -262144;
        end
        return OUT_W'(r);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_cfg = '{DRIVE_GAIN_RST, OUTPUT_GAIN_RST, WET_WEIGHT_RST,
                           DRY_WEIGHT_RST, CLAMP_LEVEL_RST};
            predicted_samples.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_DRIVE_GAIN:  shadow_cfg.drive_gain  = cfg_data[DRIVE_W-1:0];
                    REG_OUTPUT_GAIN: shadow_cfg.output_gain = cfg_data;
                    REG_WET_WEIGHT:  shadow_cfg.wet_weight  = cfg_data;
                    REG_DRY_WEIGHT:  shadow_cfg.dry_weight  = cfg_data;
                    REG_CLAMP_LEVEL: shadow_cfg.clamp_level = cfg_data;
                    default:         ;
                endcase
            end
            if (sample_valid && !sample_stall)
            begin
                predicted_samples.insert(predicted_samples.size(),
                                         distort_and_mix(sample_in, shadow_cfg));
            end
            if (result_valid && !result_stall)
            begin
                if (predicted_samples.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("sample_out %0d arrived with no transaction outstanding",
                                 sample_out);
                    end
                end
                else
                begin
                    expected = predicted_samples.pop_front();
                    if (sample_out !== expected)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("sample_out mismatch: expected %0d, got %0d",
                                     expected, sample_out);
                        end
                    end
                end
            end
        end
        pending = predicted_samples.size();
    end

endmodule

[dv/tb_tanh_distortion_mix.sv]
// Testbench top: clock, reset, stimulus and verdict for the tanh distortion mixer.
`timescale 1ns / 100ps

module tb_tanh_distortion_mix;
    import tdm_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 2 * STAGES + 4;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 225;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       sample_valid = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_in    = '0;
    logic                       result_stall = 1'b0;
    logic                       cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index    = '0;
    logic [CFG_DATA_W-1:0]      cfg_data     = '0;
    logic                       sample_stall;
    logic                       result_valid;
    logic signed [OUT_W-1:0]    sample_out;
    int                         fail_count;
    int                         pending;
    int                         idle_pct     = 19;
    logic                       hold_request = 1'b0;
    int unsigned                cycle_count  = 0;

    tanh_distortion_mix u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_in    (sample_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample_out   (sample_out),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    tdm_mix_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_in    (sample_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample_out   (sample_out),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_tanh_distortion_mix: FAIL");
            $finish;
        end
    end

    // The output side stalls at random, and once holds off long enough for the pipe to fill.
    initial
    begin
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < idle_pct);
            end
        end
    end

    task automatic offer_sample(input logic signed [SAMPLE_W-1:0] value);
        while ($urandom_range(99) < idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample_in    <= value;
        @(posedge clk);
        while (sample_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic settle();
        sample_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    // Every register is written, plus one write to an unused index that must be ignored.
    task automatic load_settings(input cfg_t s);
        put_reg(REG_DRIVE_GAIN, {1'($urandom), s.drive_gain});
        put_reg(REG_OUTPUT_GAIN, s.output_gain);
        put_reg(REG_WET_WEIGHT, s.wet_weight);
        put_reg(REG_DRY_WEIGHT, s.dry_weight);
        put_reg(REG_CLAMP_LEVEL, s.clamp_level);
        put_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, REG_CLAMP_LEVEL + 1)),
                CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic cfg_t random_settings();
        cfg_t s;
        s.drive_gain  = $urandom_range(1) ? DRIVE_W'($urandom_range(4096)) : DRIVE_W'($urandom);
        s.output_gain = GAIN_W'($urandom_range(32768, 4096));
        s.wet_weight  = GAIN_W'($urandom_range(32768));
        s.dry_weight  = GAIN_W'($urandom_range(32768));
        s.clamp_level = GAIN_W'($urandom);
        return s;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        int mag;
        case ($urandom_range(9))
            6, 7:
            begin
                mag = $urandom_range(1023);
                return SAMPLE_W'($urandom_range(1) ? -mag : mag);
            end
            8:
            begin
                mag = $urandom_range(7);
                return SAMPLE_W'($urandom_range(1) ? 32767 - mag : -32768 + mag);
            end
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial
    begin
        logic signed [SAMPLE_W-1:0] directed [12];
        cfg_t                       s;
        directed = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768, 16'sd16384,
                     -16'sd16384, 16'sd23130, -16'sd23131, 16'sd1000, -16'sd1000, 16'sd8};
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            offer_sample(directed[i]);
        end
        settle();
        s = '{DRIVE_W'(32767), GAIN_W'(65535), GAIN_W'(65535), GAIN_W'(65535), GAIN_W'(65535)};
        load_settings(s);
        foreach (directed[i])
        begin
            offer_sample(directed[i]);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: s = '{DRIVE_GAIN_RST, OUTPUT_GAIN_RST, WET_WEIGHT_RST,
                         DRY_WEIGHT_RST, CLAMP_LEVEL_RST};
                1: s = '{DRIVE_W'(0), GAIN_W'(0), GAIN_W'(0), GAIN_W'(0), GAIN_W'(0)};
                2: s = '{DRIVE_W'(1024), GAIN_W'(16384), GAIN_W'(32768), GAIN_W'(0), GAIN_W'(0)};
                5: s = '{DRIVE_W'(32767), GAIN_W'(65535), GAIN_W'(32768), GAIN_W'(32768),
                         GAIN_W'(0)};
                default: s = random_settings();
            endcase
            settle();
            load_settings(s);
            idle_pct <= (ph == 2) ? 0 : 19;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 3 && n == 40)
                begin
                    hold_request <= 1'b1;
                end
                offer_sample(random_sample());
            end
        end
        settle();

        if (fail_count == 0 && pending == 0)
        begin
            $display("tb_tanh_distortion_mix: PASS");
        end
        else
        begin
            $display("tb_tanh_distortion_mix: FAIL");
        end
        $finish;
    end

endmodule

[tanh_distortion_mix.f]
sv/tdm_pkg.sv
sv/tdm_ctrl.sv
sv/tdm_front.sv
sv/tdm_rom.sv
sv/tdm_mix.sv
sv/tanh_distortion_mix.sv
dv/tdm_mix_checker.sv
dv/tb_tanh_distortion_mix.sv
